FILE: rtl/whb_pkg.sv
`default_nettype none
package whb_pkg;

	localparam logic [63:0] P0 = 64'ha0761d6478bd642f;
	localparam logic [63:0] P1 = 64'he7037ed1a0b428db;
	localparam logic [63:0] P2 = 64'h8ebc6af09c88c6e3;
	localparam logic [63:0] P3 = 64'h589965cc75374cc3;
	localparam logic [63:0] P4 = 64'h1d8e4e27c47d124f;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [3:0][63:0] words_t;

	typedef enum logic [1:0] {
		ABS_NONE,
		ABS_PRIMARY,
		ABS_SECONDARY,
		ABS_SPLIT
	} abs_kind_t;

	typedef struct packed {
		abs_kind_t kind;
		logic      fin;
		logic      fresh;
	} op_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ABS,
		S_FSET,
		S_RUN1,
		S_WAIT1,
		S_RUN2,
		S_WAIT2,
		S_MIX,
		S_RUN3,
		S_WAIT3
	} back_state_t;

	function automatic logic [63:0] rd8(input words_t g, input logic [4:0] off);
		logic [255:0] t;
		t = g >> {off, 3'b000};
		return t[63:0];
	endfunction

	function automatic logic [63:0] rd4(input words_t g, input logic [4:0] off);
		logic [63:0] t;
		t = rd8(g, off);
		return {32'h0, t[31:0]};
	endfunction

	function automatic logic [7:0] byte_at(input words_t g, input logic [4:0] off);
		logic [63:0] t;
		t = rd8(g, off);
		return t[7:0];
	endfunction

	function automatic logic [63:0] rd3(input words_t g, input logic [5:0] k);
		logic [5:0] km1;
		km1 = k - 6'd1;
		return {40'h0, byte_at(g, 5'd0), byte_at(g, k[5:1]), byte_at(g, km1[4:0])};
	endfunction

endpackage
`default_nettype wire

FILE: rtl/whb_fifo.sv
`default_nettype none
module whb_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         rd,
	output logic [W-1:0]      rdata,
	output logic              empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/whb_front.sv
`default_nettype none
module whb_front #(
	parameter int LEN_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [63:0]         data_word,
	input  wire logic [31:0]         msg_len,
	input  wire logic [63:0]         seed_in,
	input  wire logic                last,
	input  wire logic                q_full,
	output logic                     q_push,
	output whb_pkg::op_ctl_t         q_ctl,
	output whb_pkg::words_t          q_words,
	output logic [63:0]              q_seed,
	output logic [LEN_BITS-1:0]      q_len
);
	import whb_pkg::*;

	logic                in_msg_q, fresh_q;
	logic [LEN_BITS-1:0] len_q, taken_q;
	logic [63:0]         seed_q;
	words_t              grp_q;

	logic                acc, take, full8, absorb, cur_fresh;
	logic [LEN_BITS-1:0] cur_len, cur_taken, rem, nt, chunk_end;
	logic [63:0]         cur_seed;
	words_t              cur_grp, new_grp;
	logic [1:0]          idx;
	abs_kind_t           kind;

	always_comb begin
		acc       = push && !q_full;
		cur_len   = in_msg_q ? len_q : LEN_BITS'(msg_len);
		cur_seed  = in_msg_q ? seed_q : seed_in;
		cur_taken = in_msg_q ? taken_q : '0;
		cur_grp   = in_msg_q ? grp_q : '0;
		cur_fresh = in_msg_q ? fresh_q : 1'b1;
		take      = cur_taken < cur_len;
		rem       = cur_len - cur_taken;
		full8     = rem >= LEN_BITS'(8);
		idx       = cur_taken[4:3];
		new_grp   = cur_grp;
		if (take) begin
			new_grp[idx] = data_word;
		end
		nt        = take ? cur_taken + (full8 ? LEN_BITS'(8) : rem) : cur_taken;
		absorb    = take && (idx == 2'd3) && full8 && (cur_len > LEN_BITS'(32));
		chunk_end = cur_len & ~LEN_BITS'(255);
		if (!absorb) begin
			kind = ABS_NONE;
		end else if (nt <= chunk_end) begin
			kind = nt[5] ? ABS_PRIMARY : ABS_SECONDARY;
		end else begin
			kind = ABS_SPLIT;
		end
		q_push  = acc && (absorb || last);
		q_ctl   = '{kind: kind, fin: last, fresh: cur_fresh};
		q_words = new_grp;
		q_seed  = cur_seed;
		q_len   = cur_len;
	end

	assign full = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			fresh_q  <= 1'b1;
		end else if (acc) begin
			in_msg_q <= !last;
			fresh_q  <= cur_fresh && !q_push;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			len_q   <= cur_len;
			seed_q  <= cur_seed;
			taken_q <= nt;
			grp_q   <= absorb ? '0 : new_grp;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/whb_mum.sv
`default_nettype none
module whb_mum (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      res
);
	logic [63:0] a_q, b_q, prod_s1, acc_q, term;
	logic [31:0] x, y;
	logic [1:0]  cnt_q, sel_s1;
	logic        busy_q, pv_s1, done_q;

	// order: ah*bl, al*bh (both rotated), ah*bh, al*bl
	always_comb begin
		x    = (cnt_q == 2'd0 || cnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
		y    = (cnt_q == 2'd1 || cnt_q == 2'd2) ? b_q[63:32] : b_q[31:0];
		term = sel_s1[1] ? prod_s1 : {prod_s1[31:0], prod_s1[63:32]};
	end

	assign done = done_q;
	assign res  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= pv_s1 && (sel_s1 == 2'd3);
			pv_s1  <= busy_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q ^ term;
		end
		prod_s1 <= 64'(x) * 64'(y);
		sel_s1  <= cnt_q;
	end
endmodule
`default_nettype wire

FILE: rtl/whb_back.sv
`default_nettype none
module whb_back #(
	parameter int LEN_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	output logic                     q_pop,
	input  wire whb_pkg::op_ctl_t    q_ctl,
	input  wire whb_pkg::words_t     q_words,
	input  wire logic [63:0]         q_seed,
	input  wire logic [LEN_BITS-1:0] q_len,
	output logic                     empty,
	input  wire logic                pop,
	output logic [63:0]              hash_value
);
	import whb_pkg::*;

	back_state_t         st_q, st_d;
	abs_kind_t           kind_q;
	logic                fin_q, phase_q, use2_q, ov_q;
	logic [63:0]         seed_q, lp_q, ls_q, oa1_q, ob1_q, oa2_q, ob2_q, r1_q, r2_q, hv_q;
	logic [LEN_BITS-1:0] len_q;
	words_t              w_q;

	logic                mum_start, mum_done;
	logic [63:0]         mum_a, mum_b, mum_res;

	logic                short_msg, f_use1, f_use2, len_zero;
	logic [5:0]          k;
	logic [63:0]         fa, fb, f_a1, f_b1, f_a2, f_b2;

	always_comb begin
		short_msg = len_q <= LEN_BITS'(32);
		len_zero  = len_q == '0;
		fa        = short_msg ? seed_q : lp_q;
		fb        = short_msg ? seed_q : ls_q;
		k         = short_msg ? len_q[5:0] : {1'b0, len_q[4:0]};
		f_use1    = k != 6'd0;
		f_use2    = k > 6'd16;
		f_a1      = rd8(w_q, 5'd0) ^ fa ^ P0;
		f_b1      = rd8(w_q, 5'd8) ^ fa ^ P1;
		f_a2      = rd8(w_q, 5'd16) ^ fb ^ P2;
		f_b2      = rd8(w_q, 5'(k - 6'd8)) ^ fb ^ P3;
		if (k inside {[6'd1:6'd3]}) begin
			f_a1 = rd3(w_q, k) ^ fa ^ P0;
			f_b1 = fa ^ P1;
		end else if (k inside {[6'd4:6'd8]}) begin
			f_a1 = rd4(w_q, 5'd0) ^ fa ^ P0;
			f_b1 = rd4(w_q, 5'(k - 6'd4)) ^ fa ^ P1;
		end else if (k inside {[6'd9:6'd16]}) begin
			f_b1 = rd8(w_q, 5'(k - 6'd8)) ^ fa ^ P1;
		end else if (k inside {[6'd17:6'd24]}) begin
			f_a2 = rd8(w_q, 5'(k - 6'd8)) ^ fb ^ P2;
			f_b2 = fb ^ P3;
		end
	end

	always_comb begin
		st_d      = st_q;
		q_pop     = 1'b0;
		mum_start = 1'b0;
		mum_a     = oa1_q;
		mum_b     = ob1_q;
		case (st_q)
			S_IDLE: begin
				if (!q_empty && (!q_ctl.fin || !ov_q)) begin
					q_pop = 1'b1;
					st_d  = (q_ctl.kind != ABS_NONE) ? S_ABS : S_FSET;
				end
			end
			S_ABS: st_d = S_RUN1;
			S_FSET: st_d = f_use1 ? S_RUN1 : S_MIX;
			S_RUN1: begin
				mum_start = 1'b1;
				st_d      = S_WAIT1;
			end
			S_WAIT1: begin
				if (mum_done) begin
					st_d = use2_q ? S_RUN2 : S_MIX;
				end
			end
			S_RUN2: begin
				mum_start = 1'b1;
				mum_a     = oa2_q;
				mum_b     = ob2_q;
				st_d      = S_WAIT2;
			end
			S_WAIT2: begin
				if (mum_done) begin
					st_d = S_MIX;
				end
			end
			S_MIX: begin
				if (!phase_q) begin
					st_d = fin_q ? S_FSET : S_IDLE;
				end else begin
					st_d = len_zero ? S_IDLE : S_RUN3;
				end
			end
			S_RUN3: begin
				mum_start = 1'b1;
				st_d      = S_WAIT3;
			end
			S_WAIT3: begin
				if (mum_done) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (pop && ov_q) begin
				ov_q <= 1'b0;
			end
			if ((st_q == S_MIX && phase_q && len_zero) || (st_q == S_WAIT3 && mum_done)) begin
				ov_q <= 1'b1;
			end
			if (q_pop) begin
				phase_q <= (q_ctl.kind == ABS_NONE);
			end else if (st_q == S_MIX && !phase_q && fin_q) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (q_pop) begin
					kind_q <= q_ctl.kind;
					fin_q  <= q_ctl.fin;
					seed_q <= q_seed;
					len_q  <= q_len;
					w_q    <= q_words;
					if (q_ctl.fresh) begin
						lp_q <= q_seed;
						ls_q <= q_seed;
					end
				end
			end
			S_ABS: begin
				use2_q <= 1'b1;
				if (kind_q == ABS_SECONDARY) begin
					oa1_q <= w_q[0] ^ ls_q ^ P1;
					ob1_q <= w_q[1] ^ ls_q ^ P2;
					oa2_q <= w_q[2] ^ ls_q ^ P3;
					ob2_q <= w_q[3] ^ ls_q ^ P0;
				end else begin
					oa1_q <= w_q[0] ^ lp_q ^ P0;
					ob1_q <= w_q[1] ^ lp_q ^ P1;
					oa2_q <= w_q[2] ^ ((kind_q == ABS_SPLIT) ? ls_q : lp_q) ^ P2;
					ob2_q <= w_q[3] ^ ((kind_q == ABS_SPLIT) ? ls_q : lp_q) ^ P3;
				end
			end
			S_FSET: begin
				use2_q <= f_use2;
				oa1_q  <= f_a1;
				ob1_q  <= f_b1;
				oa2_q  <= f_a2;
				ob2_q  <= f_b2;
				r1_q   <= short_msg ? '0 : lp_q;
				r2_q   <= short_msg ? '0 : ls_q;
			end
			S_WAIT1: begin
				if (mum_done) begin
					r1_q <= mum_res;
				end
			end
			S_WAIT2: begin
				if (mum_done) begin
					r2_q <= mum_res;
				end
			end
			S_MIX: begin
				if (!phase_q) begin
					case (kind_q)
						ABS_PRIMARY: lp_q <= r1_q ^ r2_q;
						ABS_SECONDARY: ls_q <= r1_q ^ r2_q;
						ABS_SPLIT: begin
							lp_q <= r1_q;
							ls_q <= r2_q;
						end
						default: ;
					endcase
					if (fin_q) begin
						w_q <= '0;
					end
				end else begin
					oa1_q <= r1_q ^ r2_q;
					ob1_q <= 64'(len_q) ^ P4;
					hv_q  <= '0;
				end
			end
			S_WAIT3: begin
				if (mum_done) begin
					hv_q <= mum_res;
				end
			end
			default: ;
		endcase
	end

	assign empty      = !ov_q;
	assign hash_value = hv_q;

	whb_mum u_mum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mum_start),
		.a      (mum_a),
		.b      (mum_b),
		.done   (mum_done),
		.res    (mum_res)
	);
endmodule
`default_nettype wire

FILE: rtl/wyhash_byte_string_hash.sv
// 64-bit wyhash of a byte message, streamed as little-endian 64-bit words.
// Input queue side: push/full. msg_len and seed_in are sampled with the first
// word of a message; last marks the final word. Output queue side: empty/pop;
// hash_value is valid while empty is low and holds until popped.
// A front end takes one word per cycle while its two-entry op queue has room;
// each completed 32-byte group of a message over 32 bytes and each message end
// queue one op for the back end, a single op when both fall on one word. The
// back end runs every mix on one 32x32 multiplier, four products per mix: a
// group takes two mixes, the finish none for an empty message, else one to
// three, plus two when the last word also completes a group. A hash waits
// while an earlier one is unpopped. Long messages are paced by the back end's
// multiplier through the op queue. Short messages without full groups queue
// only finish ops; full rises once two wait, as behind an unpopped result.
// A stalled receiver holds the result; a following finish waits in the op
// queue, one more op may queue behind it, and then full rises. Reset
// initialises the state machines, queue pointers and status flags; the block
// is idle right after reset, with no clearing pass.
`default_nettype none
module wyhash_byte_string_hash #(
	parameter int LEN_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [63:0] data_word,
	input  wire logic [31:0] msg_len,
	input  wire logic [63:0] seed_in,
	input  wire logic        last,
	output logic             empty,
	input  wire logic        pop,
	output logic [63:0]      hash_value
);
	import whb_pkg::*;

	localparam int CW = $bits(op_ctl_t);
	localparam int QW = CW + 256 + 64 + LEN_BITS;

	logic                f_push, q_full, q_empty, q_pop;
	op_ctl_t             f_ctl;
	words_t              f_words;
	logic [63:0]         f_seed;
	logic [LEN_BITS-1:0] f_len;
	logic [QW-1:0]       q_wdata, q_rdata;

	assign q_wdata = {f_ctl, f_words, f_seed, f_len};

	whb_front #(.LEN_BITS(LEN_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_word (data_word),
		.msg_len   (msg_len),
		.seed_in   (seed_in),
		.last      (last),
		.q_full    (q_full),
		.q_push    (f_push),
		.q_ctl     (f_ctl),
		.q_words   (f_words),
		.q_seed    (f_seed),
		.q_len     (f_len)
	);

	whb_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	whb_back #(.LEN_BITS(LEN_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_ctl      (op_ctl_t'(q_rdata[QW-1 -: CW])),
		.q_words    (words_t'(q_rdata[LEN_BITS+64 +: 256])),
		.q_seed     (q_rdata[LEN_BITS +: 64]),
		.q_len      (q_rdata[LEN_BITS-1:0]),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value)
	);
endmodule
`default_nettype wire
